### rtl/edfvd_pkg.sv
// Shared types, codes and constants for the EDF-VD schedulability check unit.
package edfvd_pkg;

  typedef struct packed {
    logic [1:0]  task_level;
    logic [7:0]  task_core;
    logic [15:0] util_0;
    logic [15:0] util_1;
    logic [15:0] util_2;
    logic [15:0] util_3;
    logic        last_task;
  } in_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [1:0]  level_k;
    logic [23:0] x_scale;
  } out_t;

  localparam logic [1:0]  VERDICT_FAIL = 2'd0;
  localparam logic [1:0]  VERDICT_EDF  = 2'd1;
  localparam logic [1:0]  VERDICT_VD   = 2'd2;

  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [23:0] SAT24       = 24'hFFFFFF;
  localparam int          UTIL_FIELDS = 4;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SCAN, ST_EVAL, ST_KMUL, ST_KCMP, ST_DIVL, ST_DIVR, ST_FIN, ST_OUT
  } state_e;

  typedef enum logic [1:0] {RES_FAIL, RES_EDF, RES_SAT, RES_DIV} res_e;

  typedef struct packed {
    logic acc_en;
    logic scan_init;
    logic scan_en;
    logic mat_clr;
    logic k_init;
    logic k_mul;
    logic k_step;
    logic div_start;
    logic div_sel;
    logic left_ld;
    logic res_ld;
    res_e res_kind;
    logic out_push;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic infeasible;
    logic edf_ok;
    logic k_pass;
    logic k_last;
    logic a_zero;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

### rtl/edf_vd_schedulability_check_unit.sv
// Top level of the EDF-VD mixed-criticality schedulability check unit.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_data_i) takes one task per
//    transaction. Tasks whose task_core equals the configured core are added
//    row by row into a LEVELS x LEVELS saturating sum matrix, one task a cycle.
//  - A task with last_task set closes the set. The unit then stops taking
//    transactions while it runs the test: a scan of the matrix rows, a
//    decision and, when needed, a ratio test per level k (product, then
//    compare) and two serial divisions at one quotient bit per cycle. One
//    result transaction then appears on out_valid_o/out_ready_i/out_data_o.
//  - The result sits in an output register; loading of the next set resumes
//    while it waits. A stalled receiver only holds the unit once a second
//    result is ready behind it.
//  - cfg_we_i/cfg_data_i writes the core select register (reset 0).
//  - Reset clears the matrix, the core select and all handshake state; the
//    matrix is also cleared after every test.
module edf_vd_schedulability_check_unit #(
  parameter int LEVELS = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  edfvd_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output edfvd_pkg::out_t out_data_o,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_data_i
);
  import edfvd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  edfvd_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_last_i  (in_data_i.last_task),
    .in_ready_o,
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  edfvd_dp #(.LEVELS(LEVELS)) u_dp (
    .clk_i,
    .rst_ni,
    .in_data_i,
    .cfg_we_i,
    .cfg_data_i,
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_ready_i,
    .out_valid_o,
    .out_data_o
  );
endmodule

### rtl/edfvd_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
module edfvd_div #(
  parameter int NW = 41,
  parameter int DW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);
  localparam int CW = $clog2(NW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, dvs_q;
  logic [NW-1:0] quo_q;
  logic [DW:0]   rem_sh, rem_sub;
  logic          qbit;

  always_comb begin
    rem_sh  = {rem_q, quo_q[NW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    qbit    = rem_sh >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= qbit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo_q <= {quo_q[NW-2:0], qbit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

### rtl/edfvd_dp.sv
// Datapath: sum matrix, column/diagonal scan, ratio test and result registers.
module edfvd_dp #(
  parameter int LEVELS = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  edfvd_pkg::in_t  in_data_i,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_data_i,
  input  edfvd_pkg::cmd_t cmd_i,
  output edfvd_pkg::sts_t sts_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output edfvd_pkg::out_t out_data_o
);
  import edfvd_pkg::*;

  localparam int RW = $clog2(LEVELS);
  localparam int SW = 24 + $clog2(LEVELS);
  localparam int NW = SW + 16;
  localparam int DW = 17;
  localparam int PW = 16 + SW;

  logic [7:0]    core_q;
  logic [23:0]   mat_q   [LEVELS][LEVELS];
  logic [24:0]   acc_sum [LEVELS];
  logic [23:0]   acc_row [LEVELS];
  logic [15:0]   util    [UTIL_FIELDS];
  logic [RW-1:0] lvl_idx;
  logic          acc_hit;

  logic [RW-1:0] r_q, k_q, k_nx;
  logic [SW-1:0] col_q [LEVELS];
  logic [23:0]   d_q   [LEVELS];
  logic [SW-1:0] dsum_q, a_q, c_q, b_w, c_w;
  logic [16:0]   oma_q, omb_q, oma_w, omb_w;
  logic          ok_q, ok_w, inf_w;
  logic [PW-1:0] p1_q;
  logic [33:0]   p2_q;

  logic [NW-1:0] dividend, quo, left_q, half;
  logic [DW-1:0] divisor;
  logic [NW:0]   xsum;
  logic [23:0]   x_w;
  logic          div_done;
  out_t          res_q, out_q;
  logic          out_valid_q;

  assign util[0] = in_data_i.util_0;
  assign util[1] = in_data_i.util_1;
  assign util[2] = in_data_i.util_2;
  assign util[3] = in_data_i.util_3;
  assign lvl_idx = RW'(in_data_i.task_level);
  assign acc_hit = cmd_i.acc_en && (in_data_i.task_core == core_q) &&
                   (int'(in_data_i.task_level) < LEVELS);

  // Per-lane saturating add of the incoming row.
  for (genvar lv = 0; lv < LEVELS; lv++) begin : g_acc
    if (lv < UTIL_FIELDS) begin : g_u
      assign acc_sum[lv] = {1'b0, mat_q[lvl_idx][lv]} + 25'(util[lv]);
    end else begin : g_z
      assign acc_sum[lv] = {1'b0, mat_q[lvl_idx][lv]};
    end
    assign acc_row[lv] = acc_sum[lv][24] ? SAT24 : acc_sum[lv][23:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_q <= '0;
    end else if (cfg_we_i) begin
      core_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++)
        for (int j = 0; j < LEVELS; j++)
          mat_q[i][j] <= '0;
    end else if (cmd_i.mat_clr) begin
      for (int i = 0; i < LEVELS; i++)
        for (int j = 0; j < LEVELS; j++)
          mat_q[i][j] <= '0;
    end else if (acc_hit) begin
      for (int lv = 0; lv < LEVELS; lv++)
        mat_q[lvl_idx][lv] <= acc_row[lv];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
      k_q <= '0;
    end else begin
      if (cmd_i.scan_init) r_q <= '0;
      else if (cmd_i.scan_en) r_q <= r_q + 1'b1;
      if (cmd_i.k_init) k_q <= '0;
      else if (cmd_i.k_step) k_q <= k_nx;
    end
  end

  assign k_nx  = k_q + 1'b1;
  assign b_w   = dsum_q - a_q;
  assign c_w   = col_q[k_q] - SW'(d_q[k_q]);
  assign oma_w = ONE_Q16 - a_q[16:0];
  assign omb_w = ONE_Q16 - b_w[16:0];
  assign ok_w  = (a_q < SW'(ONE_Q16)) && (b_w <= SW'(ONE_Q16));

  // Scan accumulates columns from the diagonal down plus the diagonal itself.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      dsum_q <= '0;
      for (int i = 0; i < LEVELS; i++) col_q[i] <= '0;
    end else if (cmd_i.scan_en) begin
      for (int i = 0; i < LEVELS; i++)
        if (int'(r_q) >= i) col_q[i] <= col_q[i] + SW'(mat_q[r_q][i]);
      d_q[r_q] <= mat_q[r_q][r_q];
      dsum_q   <= dsum_q + SW'(mat_q[r_q][r_q]);
    end
    if (cmd_i.k_init) a_q <= SW'(d_q[0]);
    else if (cmd_i.k_step) a_q <= a_q + SW'(d_q[k_nx]);
    if (cmd_i.k_mul) begin
      c_q   <= c_w;
      oma_q <= oma_w;
      omb_q <= omb_w;
      ok_q  <= ok_w;
      p1_q  <= PW'(a_q[15:0]) * PW'(c_w);
      p2_q  <= 34'(oma_w) * 34'(omb_w);
    end
    if (cmd_i.left_ld) left_q <= quo;
  end

  always_comb begin
    inf_w = 1'b0;
    for (int i = 0; i < LEVELS; i++)
      if (col_q[i] > SW'(ONE_Q16)) inf_w = 1'b1;
  end

  assign dividend = cmd_i.div_sel ? NW'({omb_q, 16'h0000}) : {c_q, 16'h0000};
  assign divisor  = cmd_i.div_sel ? a_q[16:0] : oma_q;

  edfvd_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign xsum = {1'b0, left_q} + {1'b0, quo};
  assign half = xsum[NW:1];
  assign x_w  = (half > NW'(SAT24)) ? SAT24 : half[23:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      case (cmd_i.res_kind)
        RES_EDF: res_q <= '{verdict: VERDICT_EDF, level_k: 2'(LEVELS - 1),
                            x_scale: 24'(ONE_Q16)};
        RES_SAT: res_q <= '{verdict: VERDICT_VD, level_k: 2'(k_q), x_scale: SAT24};
        RES_DIV: res_q <= '{verdict: VERDICT_VD, level_k: 2'(k_q), x_scale: x_w};
        default: res_q <= '{verdict: VERDICT_FAIL, level_k: 2'd0, x_scale: 24'd0};
      endcase
    end
    if (cmd_i.out_push) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o.scan_last  = (r_q == RW'(LEVELS - 1));
    sts_o.infeasible = inf_w;
    sts_o.edf_ok     = (dsum_q <= SW'(ONE_Q16));
    sts_o.k_pass     = ok_q && (p1_q < p2_q);
    sts_o.k_last     = (k_q == RW'(LEVELS - 2));
    sts_o.a_zero     = (a_q == '0);
    sts_o.div_done   = div_done;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end
endmodule

### rtl/edfvd_ctrl.sv
// Controller FSM sequencing load, scan, ratio test, division and result hand-off.
module edfvd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  input  edfvd_pkg::sts_t sts_i,
  output edfvd_pkg::cmd_t cmd_o
);
  import edfvd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_LOAD;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: if (in_valid_i && in_last_i) state_d = ST_SCAN;
      ST_SCAN: if (sts_i.scan_last) state_d = ST_EVAL;
      ST_EVAL: state_d = (sts_i.infeasible || sts_i.edf_ok) ? ST_OUT : ST_KMUL;
      ST_KMUL: state_d = ST_KCMP;
      ST_KCMP: begin
        if (sts_i.k_pass) state_d = sts_i.a_zero ? ST_OUT : ST_DIVL;
        else              state_d = sts_i.k_last ? ST_OUT : ST_KMUL;
      end
      ST_DIVL: if (sts_i.div_done) state_d = ST_DIVR;
      ST_DIVR: if (sts_i.div_done) state_d = ST_FIN;
      ST_FIN:  state_d = ST_OUT;
      ST_OUT:  if (sts_i.out_free) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o      = 1'b1;
        cmd_o.acc_en    = in_valid_i;
        cmd_o.scan_init = in_valid_i && in_last_i;
      end
      ST_SCAN: cmd_o.scan_en = 1'b1;
      ST_EVAL: begin
        cmd_o.mat_clr = 1'b1;
        if (sts_i.infeasible) begin
          cmd_o.res_ld   = 1'b1;
          cmd_o.res_kind = RES_FAIL;
        end else if (sts_i.edf_ok) begin
          cmd_o.res_ld   = 1'b1;
          cmd_o.res_kind = RES_EDF;
        end else begin
          cmd_o.k_init = 1'b1;
        end
      end
      ST_KMUL: cmd_o.k_mul = 1'b1;
      ST_KCMP: begin
        if (sts_i.k_pass) begin
          if (sts_i.a_zero) begin
            cmd_o.res_ld   = 1'b1;
            cmd_o.res_kind = RES_SAT;
          end else begin
            cmd_o.div_start = 1'b1;
          end
        end else if (sts_i.k_last) begin
          cmd_o.res_ld   = 1'b1;
          cmd_o.res_kind = RES_FAIL;
        end else begin
          cmd_o.k_step = 1'b1;
        end
      end
      ST_DIVL: begin
        cmd_o.div_sel   = 1'b1;
        cmd_o.left_ld   = sts_i.div_done;
        cmd_o.div_start = sts_i.div_done;
      end
      ST_DIVR: cmd_o.div_sel = 1'b1;
      ST_FIN: begin
        cmd_o.res_ld   = 1'b1;
        cmd_o.res_kind = RES_DIV;
      end
      ST_OUT:  cmd_o.out_push = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end
endmodule

### rtl/edfvd_chk.sv
// Port-level checker for the schedulability check unit, with its bind.
module edfvd_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input edfvd_pkg::in_t  in_data_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input edfvd_pkg::out_t out_data_o
);
  import edfvd_pkg::*;

  // A held result stays put until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Closing a set starts the test, so no transaction is taken next cycle.
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_task |=> !in_ready_o)
    else $error("input taken during test");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.verdict == VERDICT_FAIL |->
      out_data_o.level_k == 2'd0 && out_data_o.x_scale == 24'd0)
    else $error("failed verdict with nonzero fields");

  a_edf_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.verdict == VERDICT_EDF |->
      out_data_o.x_scale == 24'(ONE_Q16))
    else $error("plain EDF result with x not one");
endmodule

bind edf_vd_schedulability_check_unit edfvd_chk u_chk (.*);
